/* sv/wrs_pkg.sv */
// ----------------------------------------------------------------------------
// wrs_pkg - weighted roulette selector shared definitions
// Request and status codes, fixed-point widths and parameter defaults.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 256;
    localparam int unsigned FRAC_BITS_DEF   = 32;

    localparam int unsigned SUM_W  = 40;
    localparam int unsigned BASE_W = 33;
    localparam int unsigned MULT_W = 16;
    localparam int unsigned RAND_W = 32;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned CNTO_W = 9;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_SELECT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

/* sv/weighted_roulette_selector.sv */
// ----------------------------------------------------------------------------
// weighted_roulette_selector - cumulative weight table with roulette pick
// Builds a table of saturating running sums and picks the first entry at or
// above a random fraction.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall        | payload
//  request  | i_in_valid  | o_in_stall   | i_req_type .. i_rand_value
//  result   | o_out_valid | i_out_stall  | o_status .. o_weight_sum
//
//  Clear and unused codes go straight to the result state. Add runs the
//  shared multiplier twice, then accumulates. Select: one table read a cycle
//  through the single memory read port until a hit or the last stored entry.
//  Synchronous active-low reset empties the table; no clearing pass.
//  A new request is taken while a result is still held under stall.
module weighted_roulette_selector
    import wrs_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [BASE_W-1:0] i_base_prob,
    input  logic              i_has_first,
    input  logic [MULT_W-1:0] i_mult_first,
    input  logic              i_has_second,
    input  logic [MULT_W-1:0] i_mult_second,
    input  logic [RAND_W-1:0] i_rand_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic              o_added,
    output logic              o_picked,
    output logic [IDX_W-1:0]  o_picked_index,
    output logic [CNTO_W-1:0] o_entry_count,
    output logic [SUM_W-1:0]  o_weight_sum
);

    localparam int unsigned ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SHL    = (FRAC_BITS >= RAND_W) ? FRAC_BITS - RAND_W : 0;
    localparam int unsigned SHR    = (FRAC_BITS <  RAND_W) ? RAND_W - FRAC_BITS : 0;
    localparam logic [SUM_W:0] ONE_FIXED = (SUM_W+1)'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_ACC, S_SCAN, S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_p;
    logic                r_has1, r_has2;
    logic [MULT_W-1:0]   r_m1, r_m2;
    logic [SUM_W-1:0]    r_target;
    logic [CNT_W-1:0]    r_raddr, r_cidx;
    logic                r_rd_pend;
    logic [SUM_W-1:0]    r_rdata;
    logic [1:0]          r_res_status;
    logic                r_res_added, r_res_picked;
    logic [CNT_W-1:0]    r_res_idx;

    logic                r_out_valid;
    logic [1:0]          r_status;
    logic                r_added, r_picked;
    logic [IDX_W-1:0]    r_picked_index;
    logic [CNTO_W-1:0]   r_entry_count;
    logic [SUM_W-1:0]    r_weight_sum;

    logic [SUM_W-1:0]    r_mem [MAX_ENTRIES];

    logic                w_in_acc;
    logic [MULT_W-1:0]   w_mul_b;
    logic [SUM_W+MULT_W-1:0] w_prod;
    logic [SUM_W-1:0]    n_p;
    logic [SUM_W:0]      w_add;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    w_target;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // shared multiplier, one saturating step per cycle
    assign w_mul_b = (r_state == S_MUL1) ? r_m1 : r_m2;
    assign w_prod  = (SUM_W+MULT_W)'(r_p) * (SUM_W+MULT_W)'(w_mul_b);
    assign n_p     = (|w_prod[SUM_W+MULT_W-1:SUM_W]) ? SUM_MAX : w_prod[SUM_W-1:0];
    assign w_add   = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_p);
    assign n_sum   = w_add[SUM_W] ? SUM_MAX : w_add[SUM_W-1:0];
    assign w_target = (SUM_W'(i_rand_value) >> SHR) << SHL;

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC) begin
            r_mem[r_count[ADDR_W-1:0]] <= n_sum;
        end
        r_rdata <= r_mem[r_raddr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_has1       <= i_has_first;
                        r_has2       <= i_has_second;
                        r_m1         <= i_mult_first;
                        r_m2         <= i_mult_second;
                        r_p          <= SUM_W'(i_base_prob);
                        r_target     <= w_target;
                        r_raddr      <= '0;
                        r_cidx       <= '0;
                        r_rd_pend    <= 1'b0;
                        r_res_status <= ST_OK;
                        r_res_added  <= 1'b0;
                        r_res_picked <= 1'b0;
                        r_res_idx    <= '0;
                        r_state      <= S_OUT;
                        unique case (i_req_type)
                            REQ_CLEAR: begin
                                r_count <= '0;
                                r_sum   <= '0;
                            end
                            REQ_ADD: begin
                                if (i_base_prob != '0) begin
                                    if (r_count >= CNT_MAX) begin
                                        r_res_status <= ST_FULL;
                                    end else begin
                                        r_state <= S_MUL1;
                                    end
                                end
                            end
                            REQ_SELECT: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_EMPTY;
                                end else if ({1'b0, r_sum} > ONE_FIXED) begin
                                    r_res_status <= ST_ABOVE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL1: begin
                    if (r_has1) begin
                        r_p <= n_p;
                    end
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_has2) begin
                        r_p <= n_p;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum       <= n_sum;
                    r_count     <= r_count + CNT_W'(1);
                    r_res_added <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_SCAN: begin
                    // read issue runs one entry ahead of the compare
                    r_raddr   <= r_raddr + CNT_W'(1);
                    r_cidx    <= r_raddr;
                    r_rd_pend <= 1'b1;
                    if (r_rd_pend) begin
                        if (r_rdata >= r_target) begin
                            r_res_picked <= 1'b1;
                            r_res_idx    <= r_cidx;
                            r_state      <= S_OUT;
                        end else if ((r_cidx + CNT_W'(1)) == r_count) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid    <= 1'b1;
                        r_status       <= r_res_status;
                        r_added        <= r_res_added;
                        r_picked       <= r_res_picked;
                        r_picked_index <= IDX_W'(r_res_idx);
                        r_entry_count  <= CNTO_W'(r_count);
                        r_weight_sum   <= r_sum;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_added        = r_added;
    assign o_picked       = r_picked;
    assign o_picked_index = r_picked_index;
    assign o_entry_count  = r_entry_count;
    assign o_weight_sum   = r_weight_sum;

endmodule

/* sv/wrs_checker.sv */
// ----------------------------------------------------------------------------
// wrs_checker - port-level checks for the weighted roulette selector
// Watches handshakes and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
module wrs_checker
    import wrs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_status,
    input logic              o_added,
    input logic              o_picked,
    input logic [IDX_W-1:0]  o_picked_index,
    input logic [CNTO_W-1:0] o_entry_count,
    input logic [SUM_W-1:0]  o_weight_sum
);

    // busy after every accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken without going busy");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_picked_index) && $stable(o_weight_sum)))
        else $error("stalled result changed");

    a_added_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_added) |-> (o_status == ST_OK && !o_picked
            && o_entry_count != '0))
        else $error("add result inconsistent");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_entry_count == '0 && !o_picked))
        else $error("empty status with entries");

endmodule

bind weighted_roulette_selector wrs_checker u_wrs_checker (.*);
